// ===== rtl/core/kts_pkg.sv =====
// Shared types and codes for the keyed table with swap remove.
package kts_pkg;
    localparam int KEY_W    = 32;
    localparam int AMT_W    = 16;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int SUM_W    = 22;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_FIND   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DONE
    } state_t;

    // probe token traveling down the cell chain
    typedef struct packed {
        logic               active;
        logic               hit;
        logic [KEY_W-1:0]   key;
    } probe_t;
endpackage

// ===== rtl/core/keyed_table_swap_remove.sv =====
// Top level: key/value table built as a chain of entry cells with a controller.
// Each transaction takes one operation. Add and clear go from idle straight to the
// done state, which writes their result into the output register. Find and
// remove send the key down the chain of SLOTS cells, one cell a cycle, in the
// scan state, then pass through the last and done states; done writes their
// result into the output register. One transaction is in work at a time; a new
// one is accepted only while the output register is empty or its result is
// taken in the same cycle.
module keyed_table_swap_remove #(
    parameter int SLOTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[1:0], key[33:2], amount[49:34], zero pad [55:50]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], slot[7:2], found_amount[23:8], entry_count[30:24],
    // sum_amount[52:31], zero pad [55:53]
    output logic [55:0] m_tdata
);
    import kts_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    state_t state_reg, state_next;
    op_t              op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [AMT_W-1:0] amt_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [AMT_W-1:0] hit_amt_reg, hit_amt_next;
    logic [IDX_W:0]   step_reg, step_next;

    logic [55:0] out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    probe_t             chain [SLOTS+1];
    logic [SLOTS-1:0]   cell_match;
    logic [KEY_W-1:0]   cell_key [SLOTS];
    logic [AMT_W-1:0]   cell_amt [SLOTS];
    logic [SLOTS-1:0]   cell_wr;
    logic [KEY_W-1:0]   wr_key;
    logic [AMT_W-1:0]   wr_amt;
    logic [IDX_W-1:0]   last_idx;

    logic accept;
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    // active, hit, key
    assign chain[0] = {(state_reg == S_SCAN) && (step_reg == '0), 1'b0, key_reg};

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            kts_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .wr_en     (cell_wr[g]),
                .wr_key    (wr_key),
                .wr_amount (wr_amt),
                .in_use    (CNT_W'(g) < count_reg),
                .probe_in  (chain[g]),
                .probe_out (chain[g+1]),
                .match     (cell_match[g]),
                .key_q     (cell_key[g]),
                .amount_q  (cell_amt[g])
            );
        end
    endgenerate

    // state register and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= op_t'(s_tdata[1:0]);
            key_reg <= s_tdata[33:2];
            amt_reg <= s_tdata[49:34];
        end
        pos_reg     <= pos_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        hit_amt_reg <= hit_amt_next;
        step_reg    <= step_next;
        out_reg     <= out_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) begin
                if (op_t'(s_tdata[1:0]) == OP_FIND || op_t'(s_tdata[1:0]) == OP_REMOVE)
                    state_next = S_SCAN;
                else
                    state_next = S_DONE;
            end
            S_SCAN: if (step_reg == (IDX_W+1)'(SLOTS - 1)) state_next = S_LAST;
            S_LAST: state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [SLOT_W-1:0]  r_slot;
        logic [AMT_W-1:0]   r_found;
        status_t            r_status;
        count_next     = count_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_amt_next   = hit_amt_reg;
        step_next      = step_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cell_wr        = '0;
        wr_key         = key_reg;
        wr_amt         = amt_reg;
        r_slot         = '0;
        r_found        = '0;
        r_status       = ST_OK;

        if (out_valid_reg && m_tready) out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                step_next = '0;
                hit_next  = 1'b0;
            end
            S_SCAN: begin
                step_next = step_reg + 1'b1;
                // the probe visits cell i at step i; first match is the lowest
                if (cell_match[IDX_W'(step_reg)] && !hit_reg) begin
                    hit_next     = 1'b1;
                    hit_idx_next = IDX_W'(step_reg);
                    hit_amt_next = cell_amt[IDX_W'(step_reg)];
                end
            end
            S_LAST: begin
                pos_next = last_idx;
            end
            S_DONE: begin
                unique case (op_reg)
                    OP_ADD: begin
                        if (count_reg >= CNT_W'(SLOTS)) begin
                            r_status = ST_FULL;
                        end else begin
                            cell_wr[IDX_W'(count_reg)] = 1'b1;
                            r_slot     = SLOT_W'(count_reg);
                            count_next = count_reg + 1'b1;
                            sum_next   = sum_reg + SUM_W'(amt_reg);
                        end
                    end
                    OP_FIND: begin
                        if (hit_reg) begin
                            r_slot  = SLOT_W'(hit_idx_reg);
                            r_found = hit_amt_reg;
                        end else begin
                            r_status = ST_MISSING;
                        end
                    end
                    OP_REMOVE: begin
                        if (hit_reg) begin
                            // move last entry into the hole
                            cell_wr[hit_idx_reg] = 1'b1;
                            wr_key     = cell_key[pos_reg];
                            wr_amt     = cell_amt[pos_reg];
                            r_slot     = SLOT_W'(hit_idx_reg);
                            count_next = count_reg - 1'b1;
                            sum_next   = sum_reg - SUM_W'(hit_amt_reg);
                        end else begin
                            r_status = ST_MISSING;
                        end
                    end
                    OP_CLEAR: begin
                        count_next = '0;
                        sum_next   = '0;
                    end
                    default: ;
                endcase
                out_next = {3'b000, sum_next, COUNT_W'(count_next), r_found, r_slot,
                            r_status};
                out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOTS)) else $error("entry count exceeds table size");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready) else $error("accept while busy");
    a_done_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |=> m_tvalid) else $error("result missing after done");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata) && m_tvalid)
        else $error("stalled result changed");
endmodule

// ===== rtl/core/kts_cell.sv =====
// One table cell: holds an entry, compares a passing probe key and forwards it.
module kts_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [kts_pkg::KEY_W-1:0] wr_key,
    input  logic [kts_pkg::AMT_W-1:0] wr_amount,
    input  logic                     in_use,
    input  kts_pkg::probe_t          probe_in,
    output kts_pkg::probe_t          probe_out,
    output logic                     match,
    output logic [kts_pkg::KEY_W-1:0] key_q,
    output logic [kts_pkg::AMT_W-1:0] amount_q
);
    import kts_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [AMT_W-1:0] amount_reg;
    probe_t           probe_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_reg    <= wr_key;
            amount_reg <= wr_amount;
        end
    end

    // match asserts in the cycle the probe sits at this in-use cell and first matches
    assign match = probe_in.active && !probe_in.hit && in_use && (probe_in.key == key_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg <= '0;
        end else begin
            probe_reg.active <= probe_in.active;
            probe_reg.hit    <= probe_in.hit | match;
            probe_reg.key    <= probe_in.key;
        end
    end

    assign probe_out = probe_reg;
    assign key_q     = key_reg;
    assign amount_q  = amount_reg;
endmodule
